### hw/rtl/csr_sparse_matrix_store_macros.svh
// Assertion macros used by the checker file of the sparse matrix store.
// Depends on nothing; included by bare file name.
`ifndef CSR_SPARSE_MATRIX_STORE_MACROS_SVH
`define CSR_SPARSE_MATRIX_STORE_MACROS_SVH

// Check a property at every rising clock edge, reset included.
`define CSMS_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property at every rising clock edge outside reset.
`define CSMS_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### hw/rtl/csms_pkg.sv
// Shared types and constants of the sparse matrix store.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package csms_pkg;

    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLS_DEF    = 64;
    localparam int MAX_ENTRIES_DEF = 256;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 7;
    localparam int VAL_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS  = 2'd0,
        CFG_NUM_COLS  = 2'd1,
        CFG_DEFAULT   = 2'd2
    } t_cfg_idx;

    // Datapath operations, selected by the controller state.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLR,
        OP_RD_LO,
        OP_RD_HI,
        OP_CAP_HI,
        OP_SCAN,
        OP_SHIFT_INIT,
        OP_WR_HIT,
        OP_SHIFT,
        OP_WR_NEW,
        OP_ROW,
        OP_EMIT
    } t_dp_op;

    // Result kind loaded into the output register.
    typedef enum logic [1:0] {
        RES_OK,
        RES_RANGE,
        RES_FULL,
        RES_READ
    } t_res_sel;

    typedef struct packed {
        t_dp_op   op;
        t_res_sel res;
    } t_dp_ctl;

    typedef struct packed {
        logic is_put;
        logic is_get;
        logic is_clear;
        logic in_range;
        logic hit;
        logic full;
        logic scan_done;
        logic shift_done;
        logic row_done;
        logic sweep_done;
        logic out_free;
    } t_dp_sts;

endpackage

### hw/rtl/csms_req_if.sv
// Request channel of the sparse matrix store: valid/ready plus command payload.
// Depends on csms_pkg.
`timescale 1ns / 1ps

interface csms_req_if;
    logic                           valid;
    logic                           ready;
    logic [csms_pkg::CMD_W-1:0]     cmd;
    logic [csms_pkg::IDX_W-1:0]     row;
    logic [csms_pkg::IDX_W-1:0]     col;
    logic signed [csms_pkg::VAL_W-1:0] write_value;

    modport source (output valid, cmd, row, col, write_value, input ready);
    modport sink   (input valid, cmd, row, col, write_value, output ready);
endinterface

### hw/rtl/csms_rsp_if.sv
// Response channel of the sparse matrix store: valid/ready plus result payload.
// Depends on csms_pkg.
`timescale 1ns / 1ps

interface csms_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [csms_pkg::VAL_W-1:0] read_value;
    logic [csms_pkg::STATUS_W-1:0]     status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

### hw/rtl/csms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module csms_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/csms_ctrl.sv
// Control state machine of the sparse matrix store: sequences the datapath.
// Depends on csms_pkg.
`timescale 1ns / 1ps

module csms_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  csms_pkg::t_dp_sts  i_sts,
    output csms_pkg::t_dp_ctl  o_ctl
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_RD_HI,
        S_CAP_HI,
        S_SCAN,
        S_ACT,
        S_WR_HIT,
        S_SHIFT,
        S_WR_NEW,
        S_ROW_UP,
        S_CLEAR,
        S_EMIT
    } t_state;

    t_state              r_state;
    t_state              n_state;
    csms_pkg::t_res_sel  r_res;
    csms_pkg::t_res_sel  n_res;
    csms_pkg::t_dp_op    w_op;
    logic                w_accept;

    assign w_accept    = i_req_valid && (r_state == S_IDLE);
    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        w_op    = csms_pkg::OP_NOP;
        unique case (r_state)
            S_INIT: begin
                w_op = csms_pkg::OP_CLR;
                if (i_sts.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    w_op    = csms_pkg::OP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                w_op = csms_pkg::OP_RD_LO;
                if (i_sts.is_clear) begin
                    n_state = S_CLEAR;
                end else if (!(i_sts.is_put || i_sts.is_get)) begin
                    n_res   = csms_pkg::RES_OK;
                    n_state = S_EMIT;
                end else if (!i_sts.in_range) begin
                    n_res   = csms_pkg::RES_RANGE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_RD_HI;
                end
            end
            S_RD_HI: begin
                w_op    = csms_pkg::OP_RD_HI;
                n_state = S_CAP_HI;
            end
            S_CAP_HI: begin
                w_op    = csms_pkg::OP_CAP_HI;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                w_op = csms_pkg::OP_SCAN;
                if (i_sts.scan_done) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                w_op = csms_pkg::OP_SHIFT_INIT;
                if (i_sts.is_get) begin
                    n_res   = csms_pkg::RES_READ;
                    n_state = S_EMIT;
                end else if (i_sts.hit) begin
                    n_state = S_WR_HIT;
                end else if (i_sts.full) begin
                    n_res   = csms_pkg::RES_FULL;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_WR_HIT: begin
                w_op    = csms_pkg::OP_WR_HIT;
                n_res   = csms_pkg::RES_OK;
                n_state = S_EMIT;
            end
            S_SHIFT: begin
                w_op = csms_pkg::OP_SHIFT;
                if (i_sts.shift_done) begin
                    n_state = S_WR_NEW;
                end
            end
            S_WR_NEW: begin
                w_op    = csms_pkg::OP_WR_NEW;
                n_state = S_ROW_UP;
            end
            S_ROW_UP: begin
                w_op = csms_pkg::OP_ROW;
                if (i_sts.row_done) begin
                    n_res   = csms_pkg::RES_OK;
                    n_state = S_EMIT;
                end
            end
            S_CLEAR: begin
                w_op = csms_pkg::OP_CLR;
                if (i_sts.sweep_done) begin
                    n_res   = csms_pkg::RES_OK;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                w_op = csms_pkg::OP_EMIT;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_res   <= csms_pkg::RES_OK;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    assign o_ctl.op  = w_op;
    assign o_ctl.res = r_res;

endmodule

### hw/rtl/csms_dpath.sv
// Datapath of the sparse matrix store: config registers, row offset RAM,
// entry RAM, scan/shift pointers and the output register. Depends on
// csms_pkg and csms_ram.
`timescale 1ns / 1ps

module csms_dpath #(
    parameter int MAX_ROWS    = csms_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = csms_pkg::MAX_COLS_DEF,
    parameter int MAX_ENTRIES = csms_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [csms_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [csms_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [csms_pkg::CMD_W-1:0]            i_cmd,
    input  logic [csms_pkg::IDX_W-1:0]            i_row,
    input  logic [csms_pkg::IDX_W-1:0]            i_col,
    input  logic signed [csms_pkg::VAL_W-1:0]     i_write_value,
    input  csms_pkg::t_dp_ctl                     i_ctl,
    output csms_pkg::t_dp_sts                     o_sts,
    output logic                                  o_rsp_valid,
    input  logic                                  i_rsp_ready,
    output logic signed [csms_pkg::VAL_W-1:0]     o_read_value,
    output logic [csms_pkg::STATUS_W-1:0]         o_status
);

    localparam int IW  = csms_pkg::IDX_W;
    localparam int VW  = csms_pkg::VAL_W;
    localparam int RA_W = $clog2(MAX_ROWS + 1);
    localparam int RX_W = RA_W + 1;
    localparam int RRW  = (RX_W > IW) ? RX_W : IW;
    localparam int CW   = $clog2(MAX_COLS + 1);
    localparam int XW   = (CW > IW) ? CW : IW;
    localparam int NW   = $clog2(MAX_ENTRIES + 1);
    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EW   = CW + VW;

    // Configuration
    logic [IW-1:0]        r_num_rows, n_num_rows;
    logic [IW-1:0]        r_num_cols, n_num_cols;
    logic signed [VW-1:0] r_default, n_default;

    // Captured request
    logic [csms_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [IW-1:0]              r_row, n_row;
    logic [IW-1:0]              r_col, n_col;
    logic signed [VW-1:0]       r_wv, n_wv;

    // Walk state
    logic [RX_W-1:0] r_rix, n_rix;
    logic [RA_W-1:0] r_prix, n_prix;
    logic [NW-1:0]   r_ptr, n_ptr;
    logic [NW-1:0]   r_paddr, n_paddr;
    logic            r_pend, n_pend;
    logic            r_hit, n_hit;
    logic [NW-1:0]   r_hit_addr, n_hit_addr;
    logic [VW-1:0]   r_hit_val, n_hit_val;
    logic [NW-1:0]   r_hi, n_hi;
    logic [NW-1:0]   r_count, n_count;

    // Output register
    logic                          r_out_valid, n_out_valid;
    logic signed [VW-1:0]          r_out_rd, n_out_rd;
    logic [csms_pkg::STATUS_W-1:0] r_out_st, n_out_st;

    // RAM ports
    logic            w_row_we;
    logic [RA_W-1:0] w_row_waddr;
    logic [NW-1:0]   w_row_wdata;
    logic [RA_W-1:0] w_row_raddr;
    logic [NW-1:0]   w_row_rdata;
    logic            w_ent_we;
    logic [AW-1:0]   w_ent_waddr;
    logic [EW-1:0]   w_ent_wdata;
    logic [AW-1:0]   w_ent_raddr;
    logic [EW-1:0]   w_ent_rdata;

    logic [RRW-1:0] w_row_ext;
    logic [RRW-1:0] w_row_m1;
    logic [XW-1:0]  w_col_ext;
    logic [CW-1:0]  w_ent_col;
    logic [VW-1:0]  w_ent_val;
    logic [EW-1:0]  w_new_entry;
    logic [NW-1:0]  w_ptr_m1;
    logic           w_match;
    logic           w_scan_issue;
    logic           w_shift_issue;
    logic           w_row_issue;
    logic           w_out_free;

    csms_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_ROWS + 1)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_row_we),
        .i_wr_addr (w_row_waddr),
        .i_wr_data (w_row_wdata),
        .i_rd_addr (w_row_raddr),
        .o_rd_data (w_row_rdata)
    );

    csms_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ent_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ent_we),
        .i_wr_addr (w_ent_waddr),
        .i_wr_data (w_ent_wdata),
        .i_rd_addr (w_ent_raddr),
        .o_rd_data (w_ent_rdata)
    );

    assign w_row_ext   = RRW'(r_row);
    assign w_row_m1    = w_row_ext - RRW'(1);
    assign w_col_ext   = XW'(r_col);
    assign w_ent_col   = w_ent_rdata[EW-1 -: CW];
    assign w_ent_val   = w_ent_rdata[VW-1:0];
    assign w_new_entry = {w_col_ext[CW-1:0], r_wv};
    assign w_ptr_m1    = r_ptr - NW'(1);

    assign w_match       = r_pend && (XW'(w_ent_col) == w_col_ext);
    assign w_scan_issue  = (r_ptr < r_hi) && !r_hit && !w_match;
    assign w_shift_issue = (r_ptr > r_hi);
    assign w_row_issue   = (r_rix <= MAX_ROWS);
    assign w_out_free    = !r_out_valid || i_rsp_ready;

    always_comb begin
        n_num_rows = r_num_rows;
        n_num_cols = r_num_cols;
        n_default  = r_default;
        n_cmd      = r_cmd;
        n_row      = r_row;
        n_col      = r_col;
        n_wv       = r_wv;
        n_rix      = r_rix;
        n_prix     = r_prix;
        n_ptr      = r_ptr;
        n_paddr    = r_paddr;
        n_pend     = r_pend;
        n_hit      = r_hit;
        n_hit_addr = r_hit_addr;
        n_hit_val  = r_hit_val;
        n_hi       = r_hi;
        n_count    = r_count;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_out_rd    = r_out_rd;
        n_out_st    = r_out_st;

        w_row_we    = 1'b0;
        w_row_waddr = r_rix[RA_W-1:0];
        w_row_wdata = '0;
        w_row_raddr = r_rix[RA_W-1:0];
        w_ent_we    = 1'b0;
        w_ent_waddr = r_paddr[AW-1:0];
        w_ent_wdata = w_ent_rdata;
        w_ent_raddr = r_ptr[AW-1:0];

        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                csms_pkg::CFG_NUM_ROWS: n_num_rows = i_cfg_data[IW-1:0];
                csms_pkg::CFG_NUM_COLS: n_num_cols = i_cfg_data[IW-1:0];
                csms_pkg::CFG_DEFAULT:  n_default  = i_cfg_data[VW-1:0];
                default: ;
            endcase
        end

        unique case (i_ctl.op)
            csms_pkg::OP_NOP: ;
            csms_pkg::OP_LOAD: begin
                n_cmd = i_cmd;
                n_row = i_row;
                n_col = i_col;
                n_wv  = i_write_value;
                n_rix = '0;
            end
            csms_pkg::OP_CLR: begin
                w_row_we = 1'b1;
                n_rix    = r_rix + RX_W'(1);
                n_count  = '0;
            end
            csms_pkg::OP_RD_LO: begin
                w_row_raddr = w_row_m1[RA_W-1:0];
            end
            csms_pkg::OP_RD_HI: begin
                w_row_raddr = w_row_ext[RA_W-1:0];
                n_ptr       = w_row_rdata;
            end
            csms_pkg::OP_CAP_HI: begin
                n_hi   = w_row_rdata;
                n_pend = 1'b0;
                n_hit  = 1'b0;
            end
            csms_pkg::OP_SCAN: begin
                // Read at r_ptr now, compare the entry read last cycle.
                if (w_match) begin
                    n_hit      = 1'b1;
                    n_hit_addr = r_paddr;
                    n_hit_val  = w_ent_val;
                end
                n_pend  = w_scan_issue;
                n_paddr = r_ptr;
                if (w_scan_issue) begin
                    n_ptr = r_ptr + NW'(1);
                end
            end
            csms_pkg::OP_SHIFT_INIT: begin
                n_ptr  = r_count;
                n_pend = 1'b0;
            end
            csms_pkg::OP_WR_HIT: begin
                w_ent_we    = 1'b1;
                w_ent_waddr = r_hit_addr[AW-1:0];
                w_ent_wdata = w_new_entry;
            end
            csms_pkg::OP_SHIFT: begin
                // Read entry p-1, write it to p in the next cycle.
                w_ent_raddr = w_ptr_m1[AW-1:0];
                w_ent_we    = r_pend;
                n_pend      = w_shift_issue;
                n_paddr     = r_ptr;
                if (w_shift_issue) begin
                    n_ptr = w_ptr_m1;
                end
            end
            csms_pkg::OP_WR_NEW: begin
                w_ent_we    = 1'b1;
                w_ent_waddr = r_hi[AW-1:0];
                w_ent_wdata = w_new_entry;
                n_count     = r_count + NW'(1);
                n_rix       = w_row_ext[RX_W-1:0];
                n_pend      = 1'b0;
            end
            csms_pkg::OP_ROW: begin
                // Read-modify-write: bump the end of this row and of every later row by one.
                w_row_we    = r_pend;
                w_row_waddr = r_prix;
                w_row_wdata = w_row_rdata + NW'(1);
                n_pend      = w_row_issue;
                n_prix      = r_rix[RA_W-1:0];
                if (w_row_issue) begin
                    n_rix = r_rix + RX_W'(1);
                end
            end
            csms_pkg::OP_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = '0;
                    n_out_st    = csms_pkg::ST_OK;
                    case (i_ctl.res)
                        csms_pkg::RES_READ:  n_out_rd = r_hit ? $signed(r_hit_val) : r_default;
                        csms_pkg::RES_RANGE: n_out_st = csms_pkg::ST_RANGE;
                        csms_pkg::RES_FULL:  n_out_st = csms_pkg::ST_FULL;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= '0;
            r_num_cols  <= '0;
            r_default   <= '0;
            r_rix       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_num_rows  <= n_num_rows;
            r_num_cols  <= n_num_cols;
            r_default   <= n_default;
            r_rix       <= n_rix;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_row      <= n_row;
        r_col      <= n_col;
        r_wv       <= n_wv;
        r_prix     <= n_prix;
        r_ptr      <= n_ptr;
        r_paddr    <= n_paddr;
        r_hit_addr <= n_hit_addr;
        r_hit_val  <= n_hit_val;
        r_hi       <= n_hi;
        r_out_rd   <= n_out_rd;
        r_out_st   <= n_out_st;
    end

    assign o_sts.is_put     = (r_cmd == csms_pkg::CMD_PUT);
    assign o_sts.is_get     = (r_cmd == csms_pkg::CMD_GET);
    assign o_sts.is_clear   = (r_cmd == csms_pkg::CMD_CLEAR);
    assign o_sts.in_range   = (r_row != '0) && (r_row <= r_num_rows) && (r_row <= MAX_ROWS)
                           && (r_col != '0) && (r_col <= r_num_cols) && (r_col <= MAX_COLS);
    assign o_sts.hit        = r_hit;
    assign o_sts.full       = (r_count == MAX_ENTRIES);
    assign o_sts.scan_done  = r_hit || (!r_pend && (r_ptr >= r_hi));
    assign o_sts.shift_done = !r_pend && (r_ptr <= r_hi);
    assign o_sts.row_done   = !r_pend && (r_rix > MAX_ROWS);
    assign o_sts.sweep_done = (r_rix == MAX_ROWS);
    assign o_sts.out_free   = w_out_free;

    assign o_rsp_valid  = r_out_valid;
    assign o_read_value = r_out_rd;
    assign o_status     = r_out_st;

endmodule

### hw/rtl/csr_sparse_matrix_store.sv
// Top level of the sparse matrix store: controller plus datapath.
// Depends on csms_pkg, csms_req_if, csms_rsp_if, csms_ctrl and csms_dpath.
`timescale 1ns / 1ps

// Usage
//   i_req carries one command per transaction: put (cmd 0), get (cmd 1) or
//   clear (cmd 2), with a 1-based row and column and a put value. o_rsp returns
//   exactly one transaction per request: read_value and status (ok, range
//   error, store full). i_cfg_* writes num_rows, num_cols and default_value
//   by register index; write them only while no request is in flight.
// Sequencing
//   range error or unused command: answered straight from decode.
//   get or put: the row scan reads one entry per cycle from the entry RAM;
//   a put that misses on a full store is answered with store full.
//   put that inserts: the shift moves one entry per cycle through the entry
//   RAM port, then the row end offsets from that row on are bumped, one per
//   cycle through the row offset RAM.
//   clear: a sweep of the row offset RAM.
//   One request is worked on at a time; i_req.ready is high only when idle.
// Reset: row offsets and the entry count are cleared by a sweep of the row
//   offset RAM; i_req.ready stays low until it ends.
// Stall: a finished result waits in the output register; one more request
//   can be accepted and worked, then it holds until o_rsp is taken.

module csr_sparse_matrix_store #(
    parameter int MAX_ROWS    = csms_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = csms_pkg::MAX_COLS_DEF,
    parameter int MAX_ENTRIES = csms_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [csms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [csms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    csms_req_if.sink                          i_req,
    csms_rsp_if.source                        o_rsp
);

    csms_pkg::t_dp_ctl w_ctl;
    csms_pkg::t_dp_sts w_sts;
    logic              w_req_ready;

    // Sequence each request through the datapath.
    csms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    // Hold config, row offsets, entries and the output register.
    csms_dpath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (i_req.cmd),
        .i_row         (i_req.row),
        .i_col         (i_req.col),
        .i_write_value (i_req.write_value),
        .i_ctl         (w_ctl),
        .o_sts         (w_sts),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_read_value  (o_rsp.read_value),
        .o_status      (o_rsp.status)
    );

    assign i_req.ready = w_req_ready;

endmodule

### hw/rtl/csms_checker.sv
// Port-level checks of the sparse matrix store, bound to the top level.
// Depends on csms_pkg and csr_sparse_matrix_store_macros.svh.
`timescale 1ns / 1ps
`include "csr_sparse_matrix_store_macros.svh"

module csms_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_req_valid,
    input logic                                  i_req_ready,
    input logic                                  i_rsp_valid,
    input logic                                  i_rsp_ready,
    input logic signed [csms_pkg::VAL_W-1:0]     i_rsp_read_value,
    input logic [csms_pkg::STATUS_W-1:0]         i_rsp_status
);

    logic [1:0] r_open;
    logic [1:0] n_open;

    // Track requests accepted but not yet answered.
    always_comb begin
        n_open = r_open;
        if (i_req_valid && i_req_ready) begin
            n_open = n_open + 2'd1;
        end
        if (i_rsp_valid && i_rsp_ready) begin
            n_open = n_open - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= n_open;
        end
    end

    `CSMS_ASSERT_CLK(a_reset_not_ready, i_clk, !i_rst_n |=> !i_req_ready, "ready right after reset")
    `CSMS_ASSERT_RST(a_no_orphan_rsp, i_clk, i_rst_n, i_rsp_valid |-> (r_open != 2'd0), "response without request")
    `CSMS_ASSERT_RST(a_open_bound, i_clk, i_rst_n, r_open != 2'd3, "more than two requests in flight")
    `CSMS_ASSERT_RST(a_err_zero, i_clk, i_rst_n, (i_rsp_valid && (i_rsp_status != csms_pkg::ST_OK)) |-> (i_rsp_read_value == '0), "error response with nonzero value")
    `CSMS_ASSERT_RST(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_read_value) && $stable(i_rsp_status)), "stalled response changed")

endmodule

bind csr_sparse_matrix_store csms_checker u_csms_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_read_value (o_rsp.read_value),
    .i_rsp_status     (o_rsp.status)
);

### bench/csr_sparse_matrix_store_tb.sv
// Self-checking testbench of the compressed-sparse-row matrix store.
// Holds its own predictor of the store inside a small scoreboard class.
// Depends on csms_pkg, csms_req_if, csms_rsp_if and csr_sparse_matrix_store.
`timescale 1ns / 1ps

module csr_sparse_matrix_store_tb;

    localparam int          LIMIT_CYCLES = 2_000_000;
    localparam int          IDLE_PCT     = 18;
    localparam int          SETTLE_GAP   = 8;
    localparam int          TAIL_CYCLES  = 40;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 1500;
    localparam int          REPORT_MAX   = 10;
    localparam int          IW           = csms_pkg::IDX_W;
    localparam int          VW           = csms_pkg::VAL_W;
    localparam int          SW           = csms_pkg::STATUS_W;
    localparam int          KW           = csms_pkg::CMD_W;
    localparam int          NROWS        = csms_pkg::MAX_ROWS_DEF;
    localparam int          NCOLS        = csms_pkg::MAX_COLS_DEF;
    localparam int          NENT         = csms_pkg::MAX_ENTRIES_DEF;
    // Codes the package leaves unnamed: the spare command and register index.
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;

    typedef struct {
        logic [VW-1:0] read_value;
        logic [SW-1:0] status;
    } t_store_result;

    // Predictor of the store plus the queue of results still owed by the block.
    class csr_result_board;
        logic [IW-1:0]       rows_reg;
        logic [IW-1:0]       cols_reg;
        logic [VW-1:0]       default_reg;
        logic [8:0]          row_end [0:NROWS];
        logic [IW-1:0]       col_at [0:NENT-1];
        logic [VW-1:0]       val_at [0:NENT-1];
        logic [8:0]          n_entries;
        t_store_result       owed_results [$];
        int                  mismatches;

        function new();
            rows_reg    = '0;
            cols_reg    = '0;
            default_reg = '0;
            mismatches  = 0;
            empty_store();
        endfunction

        function void empty_store();
            foreach (row_end[i]) row_end[i] = '0;
            n_entries = '0;
        endfunction

        function void write_register(input logic [csms_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [csms_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                csms_pkg::CFG_NUM_ROWS: rows_reg    = data[IW-1:0];
                csms_pkg::CFG_NUM_COLS: cols_reg    = data[IW-1:0];
                csms_pkg::CFG_DEFAULT:  default_reg = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Apply one accepted command to the predicted store and queue its result.
        function void note_request(input logic [KW-1:0] cmd, input logic [IW-1:0] row,
                                   input logic [IW-1:0] col, input logic [VW-1:0] wv);
            t_store_result res;
            int            nr;
            int            nc;
            int            pos;
            int            hi;
            int            ins;
            res.read_value = '0;
            res.status     = csms_pkg::ST_OK;
            nr = (rows_reg > NROWS) ? NROWS : rows_reg;
            nc = (cols_reg > NCOLS) ? NCOLS : cols_reg;
            if (cmd == csms_pkg::CMD_PUT || cmd == csms_pkg::CMD_GET) begin
                if (row < 1 || row > nr || col < 1 || col > nc) begin
                    res.status = csms_pkg::ST_RANGE;
                end else begin
                    pos = -1;
                    hi  = (row_end[row] > n_entries) ? n_entries : row_end[row];
                    for (int p = row_end[row-1]; p < hi; p++) begin
                        if (col_at[p] == col) begin
                            pos = p;
                            break;
                        end
                    end
                    if (cmd == csms_pkg::CMD_GET) begin
                        res.read_value = (pos < 0) ? default_reg : val_at[pos];
                    end else if (pos >= 0) begin
                        val_at[pos] = wv;
                    end else if (n_entries >= NENT) begin
                        res.status = csms_pkg::ST_FULL;
                    end else begin
                        // Open a slot at the end of the row and push later rows up.
                        ins = (row_end[row] > n_entries) ? n_entries : row_end[row];
                        for (int i = n_entries; i > ins; i--) begin
                            col_at[i] = col_at[i-1];
                            val_at[i] = val_at[i-1];
                        end
                        col_at[ins] = col;
                        val_at[ins] = wv;
                        n_entries   = n_entries + 1'b1;
                        for (int i = row; i <= NROWS; i++) row_end[i] = row_end[i] + 1'b1;
                    end
                end
            end else if (cmd == csms_pkg::CMD_CLEAR) begin
                empty_store();
            end
            owed_results.push_back(res);
        endfunction

        // Compare one accepted response with the oldest owed result.
        function void check_response(input logic [VW-1:0] rv,
                                     input logic [SW-1:0] st);
            t_store_result want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] response with nothing owed: read_value=%h status=%0d",
                             $time, rv, st);
            end else begin
                want = owed_results.pop_front();
                if (want.read_value !== rv || want.status !== st) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("[%0t] mismatch: read_value exp %h got %h, status exp %0d got %0d",
                                 $time, want.read_value, rv, want.status, st);
                end
            end
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_wr_en;
    logic [csms_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [csms_pkg::CFG_DATA_W-1:0]     i_cfg_data;

    csms_req_if req_if ();
    csms_rsp_if rsp_if ();

    csr_sparse_matrix_store DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    csr_result_board board = new();

    longint           cycle_count = 0;
    bit               no_idle     = 1'b0;   // both sides: suppress random idling
    int               n_responses = 0;
    logic [IW-1:0]    cur_rows    = '0;
    logic [IW-1:0]    cur_cols    = '0;
    logic [IW-1:0]    put_rows [$];         // recently written cells, reused for hits
    logic [IW-1:0]    put_cols [$];

    // Free-running 100 MHz clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Watchdog: a correct run ends far below this count.
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("** csr_sparse_matrix_store: FAILED **");
        $finish;
    end

    // Response side: check every accepted transaction, stall at random, and once
    // hold off for a long stretch so the block fills up and stalls its input.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        rsp_if.ready  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
                board.check_response(rsp_if.read_value, rsp_if.status);
                n_responses++;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (!hold_done && n_responses >= HOLD_AT) begin
                hold_done     = 1'b1;
                hold_left     = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Offer one command and hold it until the block takes it; note it at the
    // accepting edge. Call right after a rising edge.
    task automatic send_request(input logic [KW-1:0] cmd, input logic [IW-1:0] row,
                                input logic [IW-1:0] col, input logic [VW-1:0] wv);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.cmd         <= cmd;
        req_if.row         <= row;
        req_if.col         <= col;
        req_if.write_value <= wv;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        board.note_request(cmd, row, col, wv);
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Write all registers while the block is idle; poke the spare index on request.
    task automatic configure(input logic [IW-1:0] rows, input logic [IW-1:0] cols,
                             input logic [VW-1:0] dflt, input bit poke_spare);
        logic [csms_pkg::CFG_DATA_W-1:0] data;
        drain_results();
        repeat (SETTLE_GAP) @(posedge i_clk);
        if (poke_spare) begin
            data = $urandom;
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= CFG_UNUSED;
            i_cfg_data  <= data;
            @(posedge i_clk);
            board.write_register(CFG_UNUSED, data);
        end
        // Fill the bits above the field with noise; the block must mask them.
        data        = $urandom;
        data[6:0]   = rows;
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= csms_pkg::CFG_NUM_ROWS;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_register(csms_pkg::CFG_NUM_ROWS, data);
        data        = $urandom;
        data[6:0]   = cols;
        i_cfg_index <= csms_pkg::CFG_NUM_COLS;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_register(csms_pkg::CFG_NUM_COLS, data);
        i_cfg_index <= csms_pkg::CFG_DEFAULT;
        i_cfg_data  <= dflt;
        @(posedge i_clk);
        board.write_register(csms_pkg::CFG_DEFAULT, dflt);
        i_cfg_wr_en <= 1'b0;
        cur_rows = rows;
        cur_cols = cols;
    endtask

    // Draw one random command: mostly in-range cells, some reused for hits,
    // a few anywhere in the field to hit the range checks.
    task automatic random_item(input int put_pct, input int clear_pct);
        logic [KW-1:0] cmd;
        logic [IW-1:0] row;
        logic [IW-1:0] col;
        logic [VW-1:0] wv;
        int            pick;
        int            nr;
        int            nc;
        int            reuse;
        int            k;
        pick = $urandom_range(0, 99);
        if (pick < clear_pct)                    cmd = csms_pkg::CMD_CLEAR;
        else if (pick < clear_pct + 2)           cmd = CMD_UNUSED;
        else if (pick < clear_pct + 2 + put_pct) cmd = csms_pkg::CMD_PUT;
        else                                     cmd = csms_pkg::CMD_GET;
        nr    = (cur_rows > NROWS) ? NROWS : cur_rows;
        nc    = (cur_cols > NCOLS) ? NCOLS : cur_cols;
        reuse = (cmd == csms_pkg::CMD_GET) ? 60 : 10;
        if (nr == 0 || nc == 0 || $urandom_range(0, 99) < 8) begin
            row = $urandom_range(0, 127);
            col = $urandom_range(0, 127);
        end else if (put_rows.size() > 0 && $urandom_range(0, 99) < reuse) begin
            k   = $urandom_range(0, put_rows.size() - 1);
            row = put_rows[k];
            col = put_cols[k];
        end else begin
            row = $urandom_range(1, nr);
            col = $urandom_range(1, nc);
        end
        case ($urandom_range(0, 9))
            0:       wv = 32'h8000_0000;
            1:       wv = 32'h7FFF_FFFF;
            default: wv = $urandom;
        endcase
        if (cmd == csms_pkg::CMD_PUT) begin
            put_rows.push_back(row);
            put_cols.push_back(col);
            if (put_rows.size() > 64) begin
                void'(put_rows.pop_front());
                void'(put_cols.pop_front());
            end
        end
        send_request(cmd, row, col, wv);
    endtask

    task automatic run_phase(input logic [IW-1:0] rows, input logic [IW-1:0] cols,
                             input logic [VW-1:0] dflt, input int n_items,
                             input int put_pct, input int clear_pct);
        configure(rows, cols, dflt, 1'b0);
        repeat (n_items) random_item(put_pct, clear_pct);
    endtask

    // Main sequence: reset, directed commands, then random phases over settings.
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        req_if.valid       = 1'b0;
        req_if.cmd         = '0;
        req_if.row         = '0;
        req_if.col         = '0;
        req_if.write_value = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at reset: zero rows and columns, so every access is out of range.
        send_request(csms_pkg::CMD_GET, 7'd1, 7'd1, 32'h0);
        send_request(csms_pkg::CMD_PUT, 7'd64, 7'd64, 32'hFFFF_FFFF);
        send_request(CMD_UNUSED, 7'd0, 7'd0, 32'h0);

        // Full-size matrix: corners, overwrite, defaults, range edges, clear.
        configure(7'd64, 7'd64, 32'h7FFF_FFFF, 1'b1);
        send_request(csms_pkg::CMD_PUT, 7'd1, 7'd1, 32'h8000_0000);
        send_request(csms_pkg::CMD_PUT, 7'd64, 7'd64, 32'h7FFF_FFFF);
        send_request(csms_pkg::CMD_PUT, 7'd1, 7'd64, 32'hFFFF_FFFF);
        send_request(csms_pkg::CMD_PUT, 7'd64, 7'd1, 32'h0);
        send_request(csms_pkg::CMD_PUT, 7'd1, 7'd1, 32'h1234_5678);
        send_request(csms_pkg::CMD_GET, 7'd1, 7'd1, 32'h0);
        send_request(csms_pkg::CMD_GET, 7'd64, 7'd64, 32'h0);
        send_request(csms_pkg::CMD_GET, 7'd1, 7'd64, 32'h0);
        send_request(csms_pkg::CMD_GET, 7'd64, 7'd1, 32'h0);
        send_request(csms_pkg::CMD_GET, 7'd2, 7'd2, 32'h0);
        send_request(csms_pkg::CMD_GET, 7'd0, 7'd5, 32'h0);
        send_request(csms_pkg::CMD_GET, 7'd5, 7'd0, 32'h0);
        send_request(csms_pkg::CMD_PUT, 7'd65, 7'd1, 32'h5555_5555);
        send_request(csms_pkg::CMD_PUT, 7'd1, 7'd65, 32'hAAAA_AAAA);
        send_request(csms_pkg::CMD_GET, 7'd127, 7'd127, 32'h0);
        // Insert mid-store: entries of rows 33..64 shift up.
        send_request(csms_pkg::CMD_PUT, 7'd32, 7'd32, 32'hA5A5_A5A5);
        send_request(csms_pkg::CMD_GET, 7'd32, 7'd32, 32'h0);
        send_request(CMD_UNUSED, 7'd127, 7'd127, 32'hFFFF_FFFF);
        send_request(csms_pkg::CMD_CLEAR, 7'd0, 7'd0, 32'h0);
        send_request(csms_pkg::CMD_GET, 7'd1, 7'd1, 32'h0);
        send_request(csms_pkg::CMD_GET, 7'd32, 7'd32, 32'h0);

        // Fill past capacity: no clears, mostly fresh cells, so later misses see full.
        run_phase(7'd64, 7'd64, 32'h8000_0000, 420, 85, 0);
        // Shrink the window over the kept store: hits still overwrite, misses stay full.
        run_phase(7'd8, 7'd8, $urandom, 120, 60, 0);
        // Back to full size with occasional clears, no idling on either side.
        no_idle = 1'b1;
        run_phase(7'd64, 7'd64, $urandom, 150, 50, 2);
        no_idle = 1'b0;
        run_phase(7'd0, 7'd64, 32'h0, 40, 50, 2);
        // Registers above the limit clamp to it.
        run_phase(7'd127, 7'd1, $urandom, 120, 50, 3);
        run_phase(7'd1, 7'd127, $urandom, 120, 50, 3);
        run_phase(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)), $urandom, 180, 55, 3);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("** csr_sparse_matrix_store: PASSED **");
        end else begin
            $display("** csr_sparse_matrix_store: FAILED **");
        end
        $finish;
    end

endmodule

### csr_sparse_matrix_store.f
+incdir+hw/rtl
hw/rtl/csms_pkg.sv
hw/rtl/csms_req_if.sv
hw/rtl/csms_rsp_if.sv
hw/rtl/csms_ram.sv
hw/rtl/csms_ctrl.sv
hw/rtl/csms_dpath.sv
hw/rtl/csr_sparse_matrix_store.sv
hw/rtl/csms_checker.sv
bench/csr_sparse_matrix_store_tb.sv
